FILE: design/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types, codes and arithmetic helpers of the particle pool update core.
// ----------------------------------------------------------------------------
package ppu_pkg;

   localparam int PPU_POOL_SIZE = 64;
   localparam int PPU_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_SPAWN = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   localparam logic [2:0] STAT_SPAWNED  = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_SURVIVOR = 3'd2;
   localparam logic [2:0] STAT_NONE     = 3'd3;
   localparam logic [2:0] STAT_CLEARED  = 3'd4;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic [30:0]        life;
   } particle_type;

   typedef struct packed {
      kind_type     kind;
      logic [30:0]  delta_time;
      particle_type part;
   } cmd_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [5:0]         slot;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [30:0]        life_left;
      logic [6:0]         alive_count;
      logic               last;
   } res_type;

   // signed Q16.16 times unsigned Q15.16 step, floor shift by 16
   function automatic logic signed [46:0] mul_dt(input logic signed [31:0] a,
                                                 input logic [30:0] dt);
      logic signed [63:0] p;
      p = a * $signed({1'b0, dt});
      return p[62:16];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [47:0] max_v;
      logic signed [47:0] min_v;
      max_v = 48'sh0000_7FFF_FFFF;
      min_v = -48'sh0000_8000_0000;
      if (v > max_v) begin
         return 32'sh7FFF_FFFF;
      end else if (v < min_v) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

FILE: design/ppu_front.sv
// ----------------------------------------------------------------------------
// ppu_front
// Accepts request items, drops unused kinds and queues commands for the engine.
// ----------------------------------------------------------------------------
module ppu_front
   import ppu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  cmd_type req_cmd,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd
);

   localparam int PTR_W = $clog2(PPU_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(PPU_QUEUE_DEPTH + 1);

   cmd_type          queue_ff [PPU_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign req_ready = (count_ff != CNT_W'(PPU_QUEUE_DEPTH));
   assign push      = req_valid && req_ready && (req_cmd.kind != KIND_NONE);
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(PPU_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(PPU_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= req_cmd;
      end
   end

endmodule

FILE: design/ppu_engine.sv
// ----------------------------------------------------------------------------
// ppu_engine
// Holds the particle store and carries out spawn, clear and tick commands.
// ----------------------------------------------------------------------------
module ppu_engine
   import ppu_pkg::*;
#(
   parameter int POOL_SIZE = PPU_POOL_SIZE
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output res_type rsp
);

   localparam int IDX_W = $clog2(POOL_SIZE);
   localparam int CNT_W = $clog2(POOL_SIZE + 1);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_CNT  = 8'b0000_0010,
      S_RD   = 8'b0000_0100,
      S_EVAL = 8'b0000_1000,
      S_VEL  = 8'b0001_0000,
      S_PMUL = 8'b0010_0000,
      S_POS  = 8'b0100_0000,
      S_EMIT = 8'b1000_0000
   } state_type;

   particle_type mem [POOL_SIZE];
   particle_type rd_q_ff;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   live_ff, live_in;
   logic [CNT_W-1:0]   surv_ff, surv_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   top_ff, top_in;
   logic [CNT_W-1:0]   src_ff, src_in;
   logic               pend_ff, pend_in;
   logic [30:0]        dt_ff, dt_in;
   particle_type       cur_ff, cur_in;
   logic signed [46:0] prod_x_ff, prod_x_in;
   logic signed [46:0] prod_y_ff, prod_y_in;
   res_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   res_type            rsp_ff, rsp_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   particle_type       wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic               out_free;
   logic               idx_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign idx_last  = ((idx_ff + 1'b1) == surv_ff);

   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      surv_in      = surv_ff;
      scan_in      = scan_ff;
      idx_in       = idx_ff;
      top_in       = top_ff;
      src_in       = src_ff;
      pend_in      = pend_ff;
      dt_in        = dt_ff;
      cur_in       = cur_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IDX_W-1:0];
      wr_data      = cur_ff;
      rd_addr      = src_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               res_in = '0;
               res_in.last = 1'b1;
               case (cmd.kind)
                  KIND_SPAWN: begin
                     if (live_ff == CNT_W'(POOL_SIZE)) begin
                        res_in.status      = STAT_FULL;
                        res_in.alive_count = 7'(live_ff);
                     end else begin
                        wr_en              = 1'b1;
                        wr_addr            = live_ff[IDX_W-1:0];
                        wr_data            = cmd.part;
                        live_in            = live_ff + 1'b1;
                        res_in.status      = STAT_SPAWNED;
                        res_in.slot        = 6'(live_ff);
                        res_in.pos_x       = cmd.part.pos_x;
                        res_in.pos_y       = cmd.part.pos_y;
                        res_in.life_left   = cmd.part.life;
                        res_in.alive_count = 7'(live_ff + 1'b1);
                     end
                     state_in = S_EMIT;
                  end
                  KIND_CLEAR: begin
                     live_in       = '0;
                     res_in.status = STAT_CLEARED;
                     state_in      = S_EMIT;
                  end
                  KIND_TICK: begin
                     dt_in    = cmd.delta_time;
                     scan_in  = '0;
                     surv_in  = '0;
                     pend_in  = 1'b0;
                     state_in = S_CNT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         // survivors are exactly the live entries whose life exceeds the step
         S_CNT: begin
            rd_addr = scan_ff[IDX_W-1:0];
            if (scan_ff < live_ff) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && (rd_q_ff.life > dt_ff)) begin
               surv_in = surv_ff + 1'b1;
            end
            if ((scan_ff == live_ff) && !pend_ff) begin
               if (surv_ff == '0) begin
                  live_in            = '0;
                  res_in             = '0;
                  res_in.status      = STAT_NONE;
                  res_in.last        = 1'b1;
                  state_in           = S_EMIT;
               end else begin
                  idx_in   = '0;
                  src_in   = '0;
                  top_in   = live_ff;
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (rd_q_ff.life <= dt_ff) begin
               // dead: the last live entry takes its place
               top_in   = top_ff - 1'b1;
               src_in   = top_ff - 1'b1;
               state_in = S_RD;
            end else begin
               cur_in      = rd_q_ff;
               cur_in.life = rd_q_ff.life - dt_ff;
               prod_x_in   = mul_dt(rd_q_ff.force_x, dt_ff);
               prod_y_in   = mul_dt(rd_q_ff.force_y, dt_ff);
               state_in    = S_VEL;
            end
         end
         S_VEL: begin
            cur_in.vel_x = sat32(48'(cur_ff.vel_x) + 48'(prod_x_ff));
            cur_in.vel_y = sat32(48'(cur_ff.vel_y) + 48'(prod_y_ff));
            state_in     = S_PMUL;
         end
         S_PMUL: begin
            prod_x_in = mul_dt(cur_ff.vel_x, dt_ff);
            prod_y_in = mul_dt(cur_ff.vel_y, dt_ff);
            state_in  = S_POS;
         end
         S_POS: begin
            cur_in.pos_x       = sat32(48'(cur_ff.pos_x) + 48'(prod_x_ff));
            cur_in.pos_y       = sat32(48'(cur_ff.pos_y) + 48'(prod_y_ff));
            wr_en              = 1'b1;
            wr_data            = cur_in;
            res_in.status      = STAT_SURVIVOR;
            res_in.slot        = 6'(idx_ff);
            res_in.pos_x       = cur_in.pos_x;
            res_in.pos_y       = cur_in.pos_y;
            res_in.life_left   = cur_ff.life;
            res_in.alive_count = 7'(surv_ff);
            res_in.last        = idx_last;
            if (idx_last) begin
               live_in = surv_ff;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               if (res_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  src_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      surv_ff   <= surv_in;
      scan_ff   <= scan_in;
      idx_ff    <= idx_in;
      top_ff    <= top_in;
      src_ff    <= src_in;
      dt_ff     <= dt_in;
      cur_ff    <= cur_in;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

endmodule

FILE: design/particle_pool_update_core.sv
// ----------------------------------------------------------------------------
// particle_pool_update_core
// Fixed pool of particles with Euler integration and swap-remove on expiry.
// ----------------------------------------------------------------------------
// Spawn and clear items take the command in the idle state and hand the result
// to the output register in the emit state. A tick first scans the live slots
// at one per cycle to count survivors. It then walks them: each survivor passes
// through the read, evaluate, velocity, position multiply, position and emit
// states, through the particle store and the two multiply stages, and each
// expired slot met before the last survivor through the read and evaluate
// states. Up to two items queue ahead of the engine, and a result waits in an
// output register while the engine goes on.
module particle_pool_update_core
   import ppu_pkg::*;
#(
   parameter int POOL_SIZE = PPU_POOL_SIZE
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [30:0]        req_delta_time,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_force_x,
   input  logic signed [31:0] req_force_y,
   input  logic [30:0]        req_lifetime,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_slot,
   output logic signed [31:0] rsp_out_pos_x,
   output logic signed [31:0] rsp_out_pos_y,
   output logic [30:0]        rsp_life_left,
   output logic [6:0]         rsp_alive_count,
   output logic               rsp_last
);

   cmd_type req_cmd;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;
   res_type rsp;

   always_comb begin
      req_cmd.kind         = kind_type'(req_kind);
      req_cmd.delta_time   = req_delta_time;
      req_cmd.part.pos_x   = req_pos_x;
      req_cmd.part.pos_y   = req_pos_y;
      req_cmd.part.vel_x   = req_vel_x;
      req_cmd.part.vel_y   = req_vel_y;
      req_cmd.part.force_x = req_force_x;
      req_cmd.part.force_y = req_force_y;
      req_cmd.part.life    = req_lifetime;
   end

   ppu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   ppu_engine #(
      .POOL_SIZE (POOL_SIZE)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_status      = rsp.status;
   assign rsp_slot        = rsp.slot;
   assign rsp_out_pos_x   = rsp.pos_x;
   assign rsp_out_pos_y   = rsp.pos_y;
   assign rsp_life_left   = rsp.life_left;
   assign rsp_alive_count = rsp.alive_count;
   assign rsp_last        = rsp.last;

`ifndef NO_ASSERTIONS
   a_survivor_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_SURVIVOR) |-> (7'(rsp_slot) < rsp_alive_count))
      else $error("survivor slot beyond alive count");
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |-> (rsp_alive_count == 7'(POOL_SIZE)))
      else $error("spawn rejected while pool not full");
   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_NONE || rsp_status == STAT_CLEARED))
      |-> (rsp_last && rsp_alive_count == 7'd0))
      else $error("empty result not final or count nonzero");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alive_count <= 7'(POOL_SIZE)))
      else $error("alive count above pool size");
`endif

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Particle pool update core testbench: directed and random spawn, tick and
// clear items on a valid/ready input, with every result checked in order
// against a scoreboard that keeps its own copy of the particle pool.
// ----------------------------------------------------------------------------
module tb_top;
   import ppu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class pool_scoreboard;
      longint pos_q[64][2];
      longint vel_q[64][2];
      longint frc_q[64][2];
      longint life_q[64];
      int     live;
      res_type pending[$];
      int     errors;

      function new();
         live = 0;
         errors = 0;
      endfunction

      // signed Q16.16 times unsigned step, floor shift
      function longint step_mul(longint a, longint dt);
         longint p;
         p = a * dt;
         return p >>> 16;
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function res_type make_res(logic [2:0] st, int s, longint px, longint py,
                                 longint lf);
         res_type r;
         r.status = st;
         r.slot = s[5:0];
         r.pos_x = px[31:0];
         r.pos_y = py[31:0];
         r.life_left = lf[30:0];
         r.alive_count = '0;
         r.last = 1'b0;
         return r;
      endfunction

      function void note_item(kind_type kind, logic [30:0] dt_in, particle_type p);
         res_type batch[$];
         longint  dt;
         longint  lf;
         longint  v;
         int      i;
         int      k;
         if (kind == KIND_NONE) return;
         if (kind == KIND_SPAWN) begin
            if (live >= PPU_POOL_SIZE) begin
               batch.push_back(make_res(STAT_FULL, 0, 0, 0, 0));
            end else begin
               pos_q[live][0] = p.pos_x;
               pos_q[live][1] = p.pos_y;
               vel_q[live][0] = p.vel_x;
               vel_q[live][1] = p.vel_y;
               frc_q[live][0] = p.force_x;
               frc_q[live][1] = p.force_y;
               life_q[live] = p.life;
               batch.push_back(make_res(STAT_SPAWNED, live, pos_q[live][0],
                                        pos_q[live][1], life_q[live]));
               live++;
            end
         end else if (kind == KIND_CLEAR) begin
            live = 0;
            batch.push_back(make_res(STAT_CLEARED, 0, 0, 0, 0));
         end else begin
            dt = dt_in;
            i = 0;
            while (i < live) begin
               lf = life_q[i] - dt;
               if (lf <= 0) begin
                  // swap-remove: last particle moves here and is examined again
                  live--;
                  pos_q[i] = pos_q[live];
                  vel_q[i] = vel_q[live];
                  frc_q[i] = frc_q[live];
                  life_q[i] = life_q[live];
                  continue;
               end
               life_q[i] = lf;
               for (k = 0; k < 2; k++) begin
                  v = clip32(vel_q[i][k] + step_mul(frc_q[i][k], dt));
                  vel_q[i][k] = v;
                  pos_q[i][k] = clip32(pos_q[i][k] + step_mul(v, dt));
               end
               batch.push_back(make_res(STAT_SURVIVOR, i, pos_q[i][0], pos_q[i][1], lf));
               i++;
            end
            if (batch.size() == 0) batch.push_back(make_res(STAT_NONE, 0, 0, 0, 0));
         end
         foreach (batch[j]) batch[j].alive_count = live[6:0];
         batch[batch.size()-1].last = 1'b1;
         foreach (batch[j]) pending.push_back(batch[j]);
      endfunction

      function void check_result(res_type got);
         res_type exp_r;
         if (pending.size() == 0) begin
            $error("unexpected result status %0d slot %0d", got.status, got.slot);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
         end
         if (got.slot !== exp_r.slot) begin
            $error("slot exp %0d got %0d", exp_r.slot, got.slot); errors++;
         end
         if (got.pos_x !== exp_r.pos_x) begin
            $error("out_pos_x exp %0d got %0d", exp_r.pos_x, got.pos_x); errors++;
         end
         if (got.pos_y !== exp_r.pos_y) begin
            $error("out_pos_y exp %0d got %0d", exp_r.pos_y, got.pos_y); errors++;
         end
         if (got.life_left !== exp_r.life_left) begin
            $error("life_left exp %0d got %0d", exp_r.life_left, got.life_left);
            errors++;
         end
         if (got.alive_count !== exp_r.alive_count) begin
            $error("alive_count exp %0d got %0d", exp_r.alive_count, got.alive_count);
            errors++;
         end
         if (got.last !== exp_r.last) begin
            $error("last exp %0d got %0d", exp_r.last, got.last); errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = KIND_NONE;
   logic [30:0]        req_delta_time = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_vel_x = '0;
   logic signed [31:0] req_vel_y = '0;
   logic signed [31:0] req_force_x = '0;
   logic signed [31:0] req_force_y = '0;
   logic [30:0]        req_lifetime = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic [5:0]         rsp_slot;
   logic signed [31:0] rsp_out_pos_x;
   logic signed [31:0] rsp_out_pos_y;
   logic [30:0]        rsp_life_left;
   logic [6:0]         rsp_alive_count;
   logic               rsp_last;

   pool_scoreboard sb = new();
   bit  calm = 1'b0;
   int  hold_request = 0;
   int  hold_left = 0;
   int  cycles = 0;
   localparam int CYCLE_LIMIT = 1000000;

   particle_pool_update_core u_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: check each transfer, then decide ready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result('{rsp_status, rsp_slot, rsp_out_pos_x, rsp_out_pos_y,
                           rsp_life_left, rsp_alive_count, rsp_last});
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 24);
      end
   end

   task automatic send_item(kind_type kind, logic [30:0] dt, particle_type p);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_delta_time <= dt;
      req_pos_x <= p.pos_x;
      req_pos_y <= p.pos_y;
      req_vel_x <= p.vel_x;
      req_vel_y <= p.vel_y;
      req_force_x <= p.force_x;
      req_force_y <= p.force_y;
      req_lifetime <= p.life;
      do @(posedge clock); while (!req_ready);
      sb.note_item(kind, dt, p);
      if (!calm && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic particle_type rand_particle(bit wild);
      particle_type p;
      p.pos_x = $urandom;
      p.pos_y = $urandom;
      if (wild) begin
         p.vel_x = $urandom; p.vel_y = $urandom;
         p.force_x = $urandom; p.force_y = $urandom;
         p.life = 31'($urandom);
      end else begin
         p.vel_x = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         p.vel_y = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         p.force_x = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         p.force_y = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         p.life = 31'($urandom_range(1, 32'h0008_0000));
      end
      return p;
   endfunction

   function automatic logic [30:0] rand_step();
      if ($urandom_range(9) < 2) return 31'($urandom);
      return 31'($urandom_range(0, 32'h0002_0000));
   endfunction

   initial begin
      particle_type p;
      particle_type z;
      int n_rand;
      int pick;
      bit filled;
      z = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pool, extremes, zero life, ignored kind
      send_item(KIND_TICK, 31'd65536, z);
      send_item(KIND_CLEAR, '0, z);
      p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF};
      send_item(KIND_SPAWN, '0, p);
      p = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'sh7FFF_FFFF, 31'd1};
      send_item(KIND_SPAWN, '0, p);
      p = '{32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, -32'sh0000_8000,
            -32'sh0000_0001, 32'sh0000_0001, 31'd0};
      send_item(KIND_SPAWN, '0, p);
      send_item(KIND_NONE, 31'h7FFF_FFFF, rand_particle(1));
      send_item(KIND_TICK, '0, z);
      send_item(KIND_TICK, 31'h0000_8000, z);
      send_item(KIND_SPAWN, '0, rand_particle(1));
      send_item(KIND_TICK, 31'h7FFF_FFFF, z);
      send_item(KIND_TICK, 31'h7FFF_FFFF, z);
      // sender pause until the pool has answered everything
      wait_drained();
      send_item(KIND_SPAWN, '0, rand_particle(0));
      send_item(KIND_TICK, 31'd1, z);
      send_item(KIND_CLEAR, '0, z);

      n_rand = 0;
      filled = 1'b0;
      while (n_rand < 116) begin
         calm = (n_rand >= 10 && n_rand < 40);
         pick = $urandom_range(99);
         if (!filled && n_rand >= 45) begin
            // fill the pool past its size while the result side holds off
            filled = 1'b1;
            hold_request = 400;
            for (int j = 0; j < 66; j++) send_item(KIND_SPAWN, '0, rand_particle(0));
            send_item(KIND_TICK, rand_step(), z);
            n_rand += 67;
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 8)) begin
               send_item(KIND_SPAWN, '0, rand_particle($urandom_range(9) < 2));
               n_rand++;
            end
            repeat ($urandom_range(1, 4)) begin
               send_item(KIND_TICK, rand_step(), z);
               n_rand++;
            end
         end else if (pick < 80) begin
            send_item(KIND_CLEAR, '0, z);
            n_rand++;
         end else begin
            send_item(kind_type'($urandom_range(3)), 31'($urandom), rand_particle(1));
            n_rand++;
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (600) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
